[hdl/adc_trimmed_mean_filter_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef ADC_TRIMMED_MEAN_FILTER_TOP_DEFINES_SVH
`define ADC_TRIMMED_MEAN_FILTER_TOP_DEFINES_SVH

// Check a property on every rising edge once reset has been released.
`define TMF_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define TMF_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/adc_tmf_pkg.sv]
package adc_tmf_pkg;

  // Sample and result widths
  localparam int unsigned SAMPLE_W      = 12;
  localparam int unsigned AVG_W         = 12;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned IN_TDATA_W    = 16;
  localparam int unsigned OUT_TDATA_W   = 16;

  // Default batch shift: batch length is 2^AVG_SHIFT + 2 samples
  localparam int unsigned AVG_SHIFT_DEF = 3;

  // Low-byte bits that carry the sample's low nibble
  localparam int unsigned LOW_NIB_W     = SAMPLE_W - BYTE_W;

  // Assemble a 12-bit sample from the two converter result bytes
  function automatic logic [SAMPLE_W-1:0] sample_from_bytes(
    input logic [BYTE_W-1:0] hi_byte,
    input logic [BYTE_W-1:0] lo_byte
  );
    return {hi_byte, lo_byte[BYTE_W-1 -: LOW_NIB_W]};
  endfunction

endpackage

[hdl/adc_trimmed_mean_filter_top.sv]
// Trimmed-mean filter for 12-bit converter results.
// Input stream: one request per conversion, result_high in in_tdata[7:0] and
// result_low in in_tdata[15:8]; the sample is result_high:result_low[7:4].
// Samples are grouped in batches of 2^AVG_SHIFT + 2 (ten by default). At the
// end of each batch one result leaves on the output stream: the batch sum
// less its largest and smallest samples, shifted right by AVG_SHIFT, in
// out_tdata[11:0]. No result is produced between batch ends.
// The last sample of a batch passes through the input register, the
// accumulator and the trim/result register before its result appears.
// Throughput: one sample per cycle while the pipeline does not hold; the three stages advance together.
// Stall: while a result sits unread in the output register the pipeline
// holds and in_tready is low; in_tready is high whenever the output register
// is empty or being read in the same cycle.
// Reset (rst_n low, synchronous): clears the batch count, sum, extremes and
// all stage valid flags; no result is pending afterwards.
module adc_trimmed_mean_filter_top
  import adc_tmf_pkg::*;
#(
  parameter int unsigned AVG_SHIFT = AVG_SHIFT_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] result_high, [15:8] result_low
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [11:0] average, [15:12] zero
);

  localparam int unsigned BATCH_LEN = (1 << AVG_SHIFT) + 2;
  localparam int unsigned SUM_W     = $clog2(BATCH_LEN * (1 << SAMPLE_W));

  logic                advance;
  logic                s_valid;
  logic [SAMPLE_W-1:0] s_sample;
  logic                b_valid;
  logic [SUM_W-1:0]    b_sum;
  logic [SAMPLE_W-1:0] b_max;
  logic [SAMPLE_W-1:0] b_min;
  logic                o_valid;
  logic [AVG_W-1:0]    o_average;

  // Advance every stage unless a result waits unread
  assign advance   = !o_valid || out_tready;
  assign in_tready = advance;

  adc_tmf_sample u_sample (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .in_valid    (in_tvalid),
    .result_high (in_tdata[BYTE_W-1:0]),
    .result_low  (in_tdata[2*BYTE_W-1:BYTE_W]),
    .s_valid     (s_valid),
    .s_sample    (s_sample)
  );

  adc_tmf_accum #(
    .AVG_SHIFT (AVG_SHIFT),
    .BATCH_LEN (BATCH_LEN),
    .SUM_W     (SUM_W)
  ) u_accum (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .s_valid  (s_valid),
    .s_sample (s_sample),
    .b_valid  (b_valid),
    .b_sum    (b_sum),
    .b_max    (b_max),
    .b_min    (b_min)
  );

  adc_tmf_trim #(
    .AVG_SHIFT (AVG_SHIFT),
    .SUM_W     (SUM_W)
  ) u_trim (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .b_valid   (b_valid),
    .b_sum     (b_sum),
    .b_max     (b_max),
    .b_min     (b_min),
    .o_valid   (o_valid),
    .o_average (o_average)
  );

  assign out_tvalid = o_valid;
  assign out_tdata  = {{(OUT_TDATA_W - AVG_W){1'b0}}, o_average};

endmodule

[hdl/adc_tmf_sample.sv]
module adc_tmf_sample
  import adc_tmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  in_valid,
  input  logic [BYTE_W-1:0]     result_high,
  input  logic [BYTE_W-1:0]     result_low,
  output logic                  s_valid,
  output logic [SAMPLE_W-1:0]   s_sample
);

  logic                valid_r;
  logic [SAMPLE_W-1:0] sample_r;

  // Capture the request and form the sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      sample_r <= sample_from_bytes(result_high, result_low);
    end
  end

  assign s_valid  = valid_r;
  assign s_sample = sample_r;

endmodule

[hdl/adc_tmf_accum.sv]
module adc_tmf_accum
  import adc_tmf_pkg::*;
#(
  parameter int unsigned AVG_SHIFT = AVG_SHIFT_DEF,
  parameter int unsigned BATCH_LEN = (1 << AVG_SHIFT) + 2,
  parameter int unsigned SUM_W     = $clog2(BATCH_LEN * (1 << SAMPLE_W))
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                s_valid,
  input  logic [SAMPLE_W-1:0] s_sample,
  output logic                b_valid,
  output logic [SUM_W-1:0]    b_sum,
  output logic [SAMPLE_W-1:0] b_max,
  output logic [SAMPLE_W-1:0] b_min
);

  localparam int unsigned CNT_W = $clog2(BATCH_LEN);

  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_W-1:0] max_r, max_nxt;
  logic [SAMPLE_W-1:0] min_r, min_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic                last_s;

  logic                bvalid_r;
  logic [SUM_W-1:0]    bsum_r;
  logic [SAMPLE_W-1:0] bmax_r;
  logic [SAMPLE_W-1:0] bmin_r;

  // Fold the new sample into the running figures
  always_comb begin
    sum_nxt = sum_r + SUM_W'(s_sample);
    max_nxt = max_r;
    min_nxt = min_r;
    if (cnt_r == '0) begin
      max_nxt = s_sample;
      min_nxt = s_sample;
    end else if (s_sample > max_r) begin
      max_nxt = s_sample;
    end else if (s_sample < min_r) begin
      min_nxt = s_sample;
    end
  end

  assign last_s = (cnt_r == CNT_W'(BATCH_LEN - 1));

  // Hold running state; clear it once the batch closes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      max_r <= '0;
      min_r <= '0;
      cnt_r <= '0;
    end else if (advance && s_valid) begin
      if (last_s) begin
        sum_r <= '0;
        max_r <= '0;
        min_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        max_r <= max_nxt;
        min_r <= min_nxt;
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // Pass the closed batch on to the trim stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
    end else if (advance) begin
      bvalid_r <= s_valid && last_s;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_valid && last_s) begin
      bsum_r <= sum_nxt;
      bmax_r <= max_nxt;
      bmin_r <= min_nxt;
    end
  end

  assign b_valid = bvalid_r;
  assign b_sum   = bsum_r;
  assign b_max   = bmax_r;
  assign b_min   = bmin_r;

endmodule

[hdl/adc_tmf_trim.sv]
module adc_tmf_trim
  import adc_tmf_pkg::*;
#(
  parameter int unsigned AVG_SHIFT = AVG_SHIFT_DEF,
  parameter int unsigned SUM_W     = $clog2(((1 << AVG_SHIFT) + 2) * (1 << SAMPLE_W))
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                b_valid,
  input  logic [SUM_W-1:0]    b_sum,
  input  logic [SAMPLE_W-1:0] b_max,
  input  logic [SAMPLE_W-1:0] b_min,
  output logic                o_valid,
  output logic [AVG_W-1:0]    o_average
);

  logic [SUM_W-1:0] less_max;
  logic [SUM_W-1:0] trimmed;
  logic [SUM_W-1:0] shifted;
  logic             valid_r;
  logic [AVG_W-1:0] avg_r;

  // Drop both extremes, floor at zero, then scale down
  always_comb begin
    less_max = b_sum - SUM_W'(b_max);
    if (less_max >= SUM_W'(b_min)) begin
      trimmed = less_max - SUM_W'(b_min);
    end else begin
      trimmed = '0;
    end
    shifted = trimmed >> AVG_SHIFT;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && b_valid) begin
      avg_r <= shifted[AVG_W-1:0];
    end
  end

  assign o_valid   = valid_r;
  assign o_average = avg_r;

endmodule

[hdl/adc_tmf_checker.sv]
`include "adc_trimmed_mean_filter_top_defines.svh"

module adc_tmf_checker
  import adc_tmf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tready,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata
);

  // Reset leaves no result pending
  `TMF_ASSERT_ALL(a_reset_empty, !rst_n |=> !out_tvalid, "result pending after reset")

  // Input is refused only while a result waits unread
  `TMF_ASSERT_RUN(a_ready_rule, in_tready == (!out_tvalid || out_tready), "in_tready wrong")

  // Padding bits above the average stay zero
  `TMF_ASSERT_RUN(a_pad_zero, out_tvalid |-> (out_tdata[OUT_TDATA_W-1:AVG_W] == '0), "pad bits set")

  // A stalled result holds
  `TMF_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

endmodule

bind adc_trimmed_mean_filter_top adc_tmf_checker u_tmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
